// ===== rtl/core/hcps_pkg.sv =====
// Shared types, constants and codes of the harmonic cross power spectrum block.
package hcps_pkg;

  localparam int NUM_DEGREES_DEF = 4096;
  localparam int DEG_W   = 12;
  localparam int COEF_W  = 16;
  localparam int PROD_W  = 2 * COEF_W;
  localparam int ADD_W   = PROD_W + 2;
  localparam int ACC_W   = 48;
  localparam int OUT_W   = 63;
  localparam int FRAC_X  = 16;
  localparam int DIV_W   = ACC_W + FRAC_X;
  localparam int DSR_W   = DEG_W + 1;
  localparam int STAT_W  = 2;
  localparam int IDX_W   = 17;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [DIV_W-1:0] OUT_MAX = {{(DIV_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic [DIV_W-1:0] NEG_LIM = {{(DIV_W-OUT_W){1'b0}}, 1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [DEG_W-1:0] LMAX_RST = {DEG_W{1'b1}};

  localparam logic OP_ACCUM   = 1'b0;
  localparam logic OP_READOUT = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_DEGREE = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_ORDER  = 2'd2;

  localparam logic REG_LMAX = 1'b0;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_ADD,
    S_DIV,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic                     opcode;
    logic [DEG_W-1:0]         degree;
    logic [DEG_W-1:0]         order;
    logic signed [COEF_W-1:0] re_first;
    logic signed [COEF_W-1:0] im_first;
    logic signed [COEF_W-1:0] re_second;
    logic signed [COEF_W-1:0] im_second;
  } coef_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] spectrum_value;
    logic [DEG_W-1:0]        degree_out;
    logic [STAT_W-1:0]       status;
  } spec_item_t;

endpackage

// ===== rtl/core/hcps_coef_if.sv =====
// Input channel carrying coefficient and readout items.
interface hcps_coef_if;
  logic                    valid;
  logic                    ready;
  hcps_pkg::coef_item_t    data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/hcps_spec_if.sv =====
// Output channel carrying spectrum result items.
interface hcps_spec_if;
  logic                    valid;
  logic                    ready;
  hcps_pkg::spec_item_t    data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/hcps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hcps_ram #(
  parameter int WIDTH = hcps_pkg::ACC_W,
  parameter int DEPTH = hcps_pkg::NUM_DEGREES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/hcps_div.sv =====
// Restoring divider, one quotient bit per cycle, for the bin readout.
module hcps_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [hcps_pkg::DIV_W-1:0]  dividend,
  input  logic [hcps_pkg::DSR_W-1:0]  divisor,
  output logic                        done,
  output logic [hcps_pkg::DIV_W-1:0]  quotient
);

  localparam int CW = $clog2(hcps_pkg::DIV_W);

  logic [hcps_pkg::DIV_W-1:0] work;
  logic [hcps_pkg::DSR_W-1:0] rem;
  logic [hcps_pkg::DSR_W-1:0] dsr;
  logic [CW-1:0]              cnt;
  logic                       busy;
  logic [hcps_pkg::DSR_W:0]   trial;
  logic [hcps_pkg::DSR_W:0]   diff;
  logic                       qbit;

  assign trial = {rem, work[hcps_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign qbit  = (trial >= {1'b0, dsr});
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(hcps_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      work <= {work[hcps_pkg::DIV_W-2:0], qbit};
      rem  <= qbit ? diff[hcps_pkg::DSR_W-1:0] : trial[hcps_pkg::DSR_W-1:0];
    end
  end

endmodule

// ===== rtl/core/harmonic_cross_power_spectrum.sv =====
// Top level of the harmonic cross power spectrum block.
//
// Channels: coef takes items (valid/ready); opcode 0 adds re1*re2 (order 0) or
// 2*(re1*re2 + im1*im2) of two Q1.15 pairs into the degree's bin, opcode 1
// reads the bin out as sum/(2l+1) with 16 extra fraction bits and clears it.
// spec returns exactly one item per accepted item, in order, with the degree
// and a status code. lmax is written through the APB port at address 0.
// Sequencing: one item is in work at a time. Accumulate items pass through
// the read, add and result states, flagged items go from read to result, and
// readouts wait in the divide state for the 64-step divider. Each item reads
// its bin; accumulates write it back and readouts clear it before the next item.
// Reset: lmax returns to 4095 and a clearing pass zeroes the bin memory, one
// entry per cycle, through every entry; coef.ready stays low meanwhile.
// Stall: a finished result waits in the output register while spec.ready is
// low; the next item is still accepted and worked on, and holds in the result
// state until the output register frees up.
module harmonic_cross_power_spectrum #(
  parameter int NUM_DEGREES = hcps_pkg::NUM_DEGREES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  hcps_coef_if.sink                   coef,
  hcps_spec_if.source                 spec,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hcps_pkg::APB_AW-1:0] paddr,
  input  logic [hcps_pkg::APB_DW-1:0] pwdata,
  output logic [hcps_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int AW = $clog2(NUM_DEGREES);

  hcps_pkg::state_t state;
  hcps_pkg::state_t state_next;

  logic [hcps_pkg::DEG_W-1:0]         lmax;
  logic [AW-1:0]                      clr_addr;
  hcps_pkg::coef_item_t               item_q;
  logic signed [hcps_pkg::PROD_W-1:0] prod_rr;
  logic signed [hcps_pkg::PROD_W-1:0] prod_ii;
  logic [hcps_pkg::ACC_W-1:0]         acc_q;
  logic [hcps_pkg::OUT_W-1:0]         res_value;
  logic                               out_valid;
  hcps_pkg::spec_item_t               out_data;

  logic                               coef_ready;
  logic                               accept;
  logic                               out_free;
  logic                               out_load;
  logic                               clr_last;
  logic                               deg_bad;
  logic                               ord_bad;
  logic                               flagged;
  logic [hcps_pkg::STAT_W-1:0]        status;
  logic [hcps_pkg::IDX_W-1:0]         in_deg_ext;
  logic [hcps_pkg::IDX_W-1:0]         q_deg_ext;

  logic                               mem_we;
  logic [AW-1:0]                      mem_waddr;
  logic [hcps_pkg::ACC_W-1:0]         mem_wdata;
  logic [hcps_pkg::ACC_W-1:0]         mem_rdata;

  logic                               div_start;
  logic                               div_done;
  logic [hcps_pkg::DIV_W-1:0]         div_quot;
  logic [hcps_pkg::ACC_W-1:0]         rd_mag;
  logic [hcps_pkg::DIV_W-1:0]         q_sat;
  logic [hcps_pkg::DIV_W-1:0]         q_signed;

  logic signed [hcps_pkg::ADD_W-1:0]  p_rr;
  logic signed [hcps_pkg::ADD_W-1:0]  p_sum;
  logic signed [hcps_pkg::ADD_W-1:0]  add_val;
  logic [hcps_pkg::ACC_W:0]           sum_wide;
  logic [hcps_pkg::ACC_W-1:0]         sum_sat;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == hcps_pkg::REG_LMAX) ?
                  hcps_pkg::APB_DW'(lmax) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      lmax <= hcps_pkg::LMAX_RST;
    end else if (psel && penable && pwrite && paddr[2] == hcps_pkg::REG_LMAX) begin
      lmax <= pwdata[hcps_pkg::DEG_W-1:0];
    end
  end

  // item checks
  assign in_deg_ext = hcps_pkg::IDX_W'(coef.data.degree);
  assign q_deg_ext  = hcps_pkg::IDX_W'(item_q.degree);
  assign deg_bad = (item_q.degree > lmax) ||
                   (q_deg_ext >= hcps_pkg::IDX_W'(NUM_DEGREES));
  assign ord_bad = (item_q.opcode == hcps_pkg::OP_ACCUM) &&
                   (item_q.order > item_q.degree);
  assign flagged = deg_bad || ord_bad;
  assign status  = deg_bad ? hcps_pkg::STATUS_DEGREE :
                   ord_bad ? hcps_pkg::STATUS_ORDER : hcps_pkg::STATUS_OK;

  assign accept   = coef.valid && coef_ready;
  assign out_free = !out_valid || spec.ready;
  assign clr_last = (clr_addr == AW'(NUM_DEGREES - 1));

  // accumulate datapath
  assign p_rr    = hcps_pkg::ADD_W'(prod_rr);
  assign p_sum   = p_rr + hcps_pkg::ADD_W'(prod_ii);
  assign add_val = (item_q.order == '0) ? p_rr : (p_sum <<< 1);
  assign sum_wide = {acc_q[hcps_pkg::ACC_W-1], acc_q} +
                    (hcps_pkg::ACC_W+1)'(add_val);
  assign sum_sat = (sum_wide[hcps_pkg::ACC_W] == sum_wide[hcps_pkg::ACC_W-1]) ?
                   sum_wide[hcps_pkg::ACC_W-1:0] :
                   (sum_wide[hcps_pkg::ACC_W] ? hcps_pkg::ACC_MIN : hcps_pkg::ACC_MAX);

  // readout datapath
  assign rd_mag = mem_rdata[hcps_pkg::ACC_W-1] ? ('0 - mem_rdata) : mem_rdata;
  assign q_sat = acc_q[hcps_pkg::ACC_W-1] ?
                 ((div_quot > hcps_pkg::NEG_LIM) ? hcps_pkg::NEG_LIM : div_quot) :
                 ((div_quot > hcps_pkg::OUT_MAX) ? hcps_pkg::OUT_MAX : div_quot);
  assign q_signed = acc_q[hcps_pkg::ACC_W-1] ? ('0 - q_sat) : q_sat;

  hcps_ram #(
    .WIDTH (hcps_pkg::ACC_W),
    .DEPTH (NUM_DEGREES)
  ) u_bins (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (in_deg_ext[AW-1:0]),
    .rdata (mem_rdata)
  );

  hcps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({rd_mag, {hcps_pkg::FRAC_X{1'b0}}}),
    .divisor  ({item_q.degree, 1'b1}),
    .done     (div_done),
    .quotient (div_quot)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hcps_pkg::S_CLEAR: begin
        if (clr_last) state_next = hcps_pkg::S_IDLE;
      end
      hcps_pkg::S_IDLE: begin
        if (accept) state_next = hcps_pkg::S_READ;
      end
      hcps_pkg::S_READ: begin
        if (flagged) state_next = hcps_pkg::S_RESULT;
        else if (item_q.opcode == hcps_pkg::OP_ACCUM) state_next = hcps_pkg::S_ADD;
        else state_next = hcps_pkg::S_DIV;
      end
      hcps_pkg::S_ADD: begin
        state_next = hcps_pkg::S_RESULT;
      end
      hcps_pkg::S_DIV: begin
        if (div_done) state_next = hcps_pkg::S_RESULT;
      end
      hcps_pkg::S_RESULT: begin
        if (out_free) state_next = hcps_pkg::S_IDLE;
      end
      default: state_next = hcps_pkg::S_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    coef_ready = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = q_deg_ext[AW-1:0];
    mem_wdata  = '0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      hcps_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      hcps_pkg::S_IDLE: begin
        coef_ready = 1'b1;
      end
      hcps_pkg::S_READ: begin
        if (!flagged && item_q.opcode == hcps_pkg::OP_READOUT) begin
          mem_we    = 1'b1;
          div_start = 1'b1;
        end
      end
      hcps_pkg::S_ADD: begin
        mem_we    = 1'b1;
        mem_wdata = sum_sat;
      end
      hcps_pkg::S_DIV: begin
      end
      hcps_pkg::S_RESULT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  assign coef.ready = coef_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hcps_pkg::S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == hcps_pkg::S_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (out_load) out_valid <= 1'b1;
      else if (spec.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_q <= coef.data;
    if (state == hcps_pkg::S_READ) begin
      prod_rr   <= item_q.re_first * item_q.re_second;
      prod_ii   <= item_q.im_first * item_q.im_second;
      acc_q     <= mem_rdata;
      res_value <= '0;
    end
    if (state == hcps_pkg::S_DIV && div_done) res_value <= q_signed[hcps_pkg::OUT_W-1:0];
    if (out_load) begin
      out_data.spectrum_value <= res_value;
      out_data.degree_out     <= item_q.degree;
      out_data.status         <= status;
    end
  end

  assign spec.valid = out_valid;
  assign spec.data  = out_data;

  // checks
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == hcps_pkg::S_READ) && !coef.ready)
    else $error("accepted item did not start a bin read");

  a_flag_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == hcps_pkg::S_READ && flagged) |-> !mem_we)
    else $error("flagged item wrote the bin memory");

  a_nonzero_write: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state != hcps_pkg::S_ADD) |-> (mem_wdata == '0))
    else $error("clear or readout wrote a nonzero bin");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == hcps_pkg::S_DIV))
    else $error("divider finished outside the readout state");

endmodule
